// ===== src/kml_pkg.sv =====
// ----------------------------------------------------------------------------
// kml_pkg: shared constants and types of the k-means clustering block
// Sizes of the stores, command and result codes, register indexes and the
// request word that the sequencer hands to the mean divider.
// ----------------------------------------------------------------------------
package kml_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_DIMS     = 4;
  localparam int COORD_WIDTH  = 16;

  localparam int PIDX_W = $clog2(MAX_POINTS);
  localparam int CIDX_W = $clog2(MAX_CLUSTERS);
  localparam int DIDX_W = $clog2(MAX_DIMS);
  localparam int PADDR_W = PIDX_W + DIDX_W;
  localparam int CADDR_W = CIDX_W + DIDX_W;
  localparam int CENT_DEPTH = MAX_CLUSTERS * MAX_DIMS;
  localparam int PT_DEPTH   = MAX_POINTS * MAX_DIMS;

  // Field widths of the channels and registers.
  localparam int CMD_W    = 2;
  localparam int ITEM_W   = 10;
  localparam int DIM_W    = 2;
  localparam int KIND_W   = 2;
  localparam int NCL_W    = 5;
  localparam int NIT_W    = 8;
  localparam int NDIM_W   = 3;
  localparam int NPT_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  // Datapath widths: sums, counts, distances.
  localparam int SUM_W  = 27;
  localparam int CNT_W  = 11;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int DIST_W = SQ_W + DIDX_W;

  localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RD_ASG   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RD_CENT  = 2'd3;

  localparam logic [KIND_W-1:0] RK_DONE = 2'd0;
  localparam logic [KIND_W-1:0] RK_ASG  = 2'd1;
  localparam logic [KIND_W-1:0] RK_CENT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ITERATIONS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS     = 2'd3;

  // Request word from the sequencer to the mean divider.
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

endpackage

// ===== src/kml_ram.sv =====
// ----------------------------------------------------------------------------
// kml_ram: generic simple dual-port RAM
// One write port and one read port; the read word is registered.
// ----------------------------------------------------------------------------
module kml_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/kml_div.sv =====
// ----------------------------------------------------------------------------
// kml_div: serial mean divider
// Divides a signed cluster sum by an unsigned count, one quotient bit per
// cycle, and truncates the quotient toward zero.
// ----------------------------------------------------------------------------
module kml_div (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  kml_pkg::div_req_t                          req,
  output logic                                       done,
  output logic signed [kml_pkg::COORD_WIDTH-1:0]     quot
);
  import kml_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  shq_r, shq_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic              neg_r, neg_nxt;
  logic              done_nxt;
  logic signed [COORD_WIDTH-1:0] quot_nxt;
  logic [CNT_W:0]    trial;
  logic [SUM_W-1:0]  mag;

  // One restoring step per cycle on the magnitude.
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    shq_nxt  = shq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    quot_nxt = quot;
    trial    = {rem_r, shq_r[SUM_W-1]};
    mag      = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      neg_nxt  = req.dividend[SUM_W-1];
      shq_nxt  = req.dividend[SUM_W-1] ? (SUM_W)'(-req.dividend) : req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = CNT_W'(trial - {1'b0, dvs_r});
        shq_nxt = {shq_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W-1:0];
        shq_nxt = {shq_r[SUM_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        mag      = shq_nxt;
        quot_nxt = neg_r ? COORD_WIDTH'(-mag) : COORD_WIDTH'(mag);
      end
    end
  end

  // Control state takes reset; the data path does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done   <= done_nxt;
    end
    step_r <= step_nxt;
    shq_r  <= shq_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
    quot   <= quot_nxt;
  end

endmodule

// ===== src/kmeans_lloyd_clustering.sv =====
// ----------------------------------------------------------------------------
// kmeans_lloyd_clustering: Lloyd k-means over a store of Q8.8 points
// Command-driven clustering engine built around on-chip memories.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken when start is high and busy is low. Load words
//   write one coordinate into the point memory and give no result. Read words
//   (assignment or centroid coordinate) give one result word in the next
//   cycle; loads and reads are taken one per cycle.
//   A run word raises busy until the whole run is finished, then one done
//   word appears. In the mean step a cluster with no points skips the divider
//   and keeps its centroid. The run time is set by the single read port of
//   the centroid memory in the distance loop and by the serial divider that
//   forms the means.
//   Each result is shown for one cycle with out_strobe; the receiver cannot
//   stall it. Registers are to be written by the user on the cfg port only
//   while the block is idle; the block itself does not enforce this.
//   After reset the registers hold their defaults, centroids and assignments
//   read as zero through valid bits and a fill count; there is no clearing
//   pass and the block is ready at once.
// ----------------------------------------------------------------------------
module kmeans_lloyd_clustering (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [kml_pkg::CMD_W-1:0]              in_command,
  input  logic [kml_pkg::ITEM_W-1:0]             in_item_index,
  input  logic [kml_pkg::DIM_W-1:0]              in_dim_index,
  input  logic signed [kml_pkg::COORD_WIDTH-1:0] in_coord_value,
  output logic                                   out_strobe,
  output logic [kml_pkg::KIND_W-1:0]             out_result_kind,
  output logic [kml_pkg::CIDX_W-1:0]             out_cluster_id,
  output logic signed [kml_pkg::COORD_WIDTH-1:0] out_centroid_value,
  input  logic                                   cfg_we,
  input  logic [kml_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [kml_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import kml_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SEED = 8'b0000_0010,
    S_INIT = 8'b0000_0100,
    S_LDPT = 8'b0000_1000,
    S_DIST = 8'b0001_0000,
    S_UPD  = 8'b0010_0000,
    S_MEAN = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  // Configuration registers.
  logic [NCL_W-1:0]  ncl_r;
  logic [NIT_W-1:0]  nit_r;
  logic [NDIM_W-1:0] ndim_r;
  logic [NPT_W-1:0]  npt_r;

  // Sequencer state.
  state_t            state_r, state_nxt;
  logic [NCL_W-1:0]  c_r, c_nxt;
  logic [NDIM_W-1:0] d_r, d_nxt;
  logic [NPT_W-1:0]  p_r, p_nxt;
  logic [NIT_W-1:0]  it_r, it_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [NCL_W-1:0]  k_r, k_nxt;
  logic [NDIM_W-1:0] dims_r, dims_nxt;
  logic [NPT_W-1:0]  np_r, np_nxt;
  logic signed [COORD_WIDTH-1:0] pt_r [MAX_DIMS];
  logic signed [COORD_WIDTH-1:0] pt_nxt [MAX_DIMS];
  logic [DIST_W-1:0] acc_r, acc_nxt;
  logic [DIST_W-1:0] bestd_r, bestd_nxt;
  logic [CIDX_W-1:0] best_r, best_nxt;
  logic [CENT_DEPTH-1:0]   cval_r, cval_nxt;
  logic [MAX_CLUSTERS-1:0] sval_r, sval_nxt;
  logic [NPT_W-1:0]  asg_cnt_r, asg_cnt_nxt;
  logic              cen_rv_r, cen_rv_nxt;

  // Pending result word.
  logic              pend_r, pend_nxt;
  logic [KIND_W-1:0] pkind_r, pkind_nxt;
  logic              pok_r, pok_nxt;

  // Memory ports.
  logic                    pt_we;
  logic [PADDR_W-1:0]      pt_waddr, pt_raddr;
  logic [COORD_WIDTH-1:0]  pt_q;
  logic                    cen_we;
  logic [CADDR_W-1:0]      cen_waddr, cen_raddr;
  logic [COORD_WIDTH-1:0]  cen_wdata, cen_q;
  logic                    sum_we;
  logic [CADDR_W-1:0]      sum_addr;
  logic [SUM_W-1:0]        sum_wdata, sum_q;
  logic                    cnt_we;
  logic [CIDX_W-1:0]       cnt_addr;
  logic [CNT_W-1:0]        cnt_wdata, cnt_q;
  logic                    asg_we;
  logic [PIDX_W-1:0]       asg_waddr, asg_raddr;
  logic [CIDX_W-1:0]       asg_q;

  div_req_t                      div_req;
  logic                          div_done;
  logic signed [COORD_WIDTH-1:0] div_quot;

  logic                    accept;
  logic [NPT_W-1:0]        np_eff;
  logic [NCL_W-1:0]        k_eff;
  logic [NDIM_W-1:0]       dims_eff;
  logic signed [COORD_WIDTH-1:0] cq;
  logic signed [DIFF_W-1:0] diff;
  logic signed [SQ_W-1:0]   sq;
  logic [DIST_W-1:0]        dd;
  logic                     last_d;
  logic                     last_c;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign last_d = (d_r == dims_r - 1'b1);
  assign last_c = (c_r == k_r - 1'b1);

  // Clamp the registers to their working ranges.
  always_comb begin
    np_eff = npt_r;
    if (npt_r == '0) begin
      np_eff = NPT_W'(1);
    end else if (npt_r > NPT_W'(MAX_POINTS)) begin
      np_eff = NPT_W'(MAX_POINTS);
    end
    k_eff = ncl_r;
    if (ncl_r == '0) begin
      k_eff = NCL_W'(1);
    end else if (ncl_r > NCL_W'(MAX_CLUSTERS)) begin
      k_eff = NCL_W'(MAX_CLUSTERS);
    end
    if (NPT_W'(k_eff) > np_eff) begin
      k_eff = NCL_W'(np_eff);
    end
    dims_eff = ndim_r;
    if (ndim_r == '0) begin
      dims_eff = NDIM_W'(1);
    end else if (ndim_r > NDIM_W'(MAX_DIMS)) begin
      dims_eff = NDIM_W'(MAX_DIMS);
    end
  end

  // Distance term for the current coordinate.
  assign cq   = cen_rv_r ? $signed(cen_q) : '0;
  assign diff = DIFF_W'(pt_r[d_r[DIDX_W-1:0]]) - DIFF_W'(cq);
  assign sq   = diff * diff;
  assign dd   = acc_r + DIST_W'($unsigned(sq));

  // Sequencer and memory control.
  always_comb begin
    state_nxt   = state_r;
    c_nxt       = c_r;
    d_nxt       = d_r;
    p_nxt       = p_r;
    it_nxt      = it_r;
    ph_nxt      = ph_r;
    k_nxt       = k_r;
    dims_nxt    = dims_r;
    np_nxt      = np_r;
    pt_nxt      = pt_r;
    acc_nxt     = acc_r;
    bestd_nxt   = bestd_r;
    best_nxt    = best_r;
    cval_nxt    = cval_r;
    sval_nxt    = sval_r;
    asg_cnt_nxt = asg_cnt_r;
    cen_rv_nxt  = cen_rv_r;
    pend_nxt    = 1'b0;
    pkind_nxt   = pkind_r;
    pok_nxt     = pok_r;

    pt_we     = 1'b0;
    pt_waddr  = {in_item_index, in_dim_index};
    pt_raddr  = {p_r[PIDX_W-1:0], d_r[DIDX_W-1:0]};
    cen_we    = 1'b0;
    cen_waddr = {c_r[CIDX_W-1:0], d_r[DIDX_W-1:0]};
    cen_wdata = pt_q;
    cen_raddr = {c_r[CIDX_W-1:0], d_r[DIDX_W-1:0]};
    sum_we    = 1'b0;
    sum_addr  = {best_r, d_r[DIDX_W-1:0]};
    sum_wdata = (sval_r[best_r] ? sum_q : '0) + SUM_W'(pt_r[d_r[DIDX_W-1:0]]);
    cnt_we    = 1'b0;
    cnt_addr  = best_r;
    cnt_wdata = (sval_r[best_r] ? cnt_q : '0) + 1'b1;
    asg_we    = 1'b0;
    asg_waddr = p_r[PIDX_W-1:0];
    asg_raddr = in_item_index;
    div_req.start    = 1'b0;
    div_req.dividend = $signed(sum_q);
    div_req.divisor  = cnt_q;

    case (state_r)
      S_IDLE: begin
        cen_raddr  = {in_item_index[CIDX_W-1:0], in_dim_index};
        cen_rv_nxt = cval_r[{in_item_index[CIDX_W-1:0], in_dim_index}];
        if (accept) begin
          case (in_command)
            CMD_LOAD: begin
              pt_we = 1'b1;
            end
            CMD_RUN: begin
              state_nxt   = S_SEED;
              k_nxt       = k_eff;
              dims_nxt    = dims_eff;
              np_nxt      = np_eff;
              c_nxt       = '0;
              d_nxt       = '0;
              ph_nxt      = '0;
              asg_cnt_nxt = '0;
            end
            CMD_RD_ASG: begin
              pend_nxt  = 1'b1;
              pkind_nxt = RK_ASG;
              pok_nxt   = (NPT_W'(in_item_index) < asg_cnt_r);
            end
            default: begin
              pend_nxt  = 1'b1;
              pkind_nxt = RK_CENT;
              pok_nxt   = (in_item_index < ITEM_W'(MAX_CLUSTERS));
            end
          endcase
        end
      end

      // Copy point c into centroid c.
      S_SEED: begin
        pt_raddr = {PIDX_W'(c_r[CIDX_W-1:0]), d_r[DIDX_W-1:0]};
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt = 2'd0;
          cen_we = 1'b1;
          cval_nxt[{c_r[CIDX_W-1:0], d_r[DIDX_W-1:0]}] = 1'b1;
          if (last_d) begin
            d_nxt = '0;
            if (last_c) begin
              it_nxt = '0;
              if (nit_r == '0) begin
                state_nxt = S_DONE;
              end else begin
                asg_cnt_nxt = np_r;
                state_nxt   = S_INIT;
              end
            end else begin
              c_nxt = c_r + 1'b1;
            end
          end else begin
            d_nxt = d_r + 1'b1;
          end
        end
      end

      // Start of a pass: empty every cluster.
      S_INIT: begin
        sval_nxt  = '0;
        p_nxt     = '0;
        d_nxt     = '0;
        ph_nxt    = '0;
        state_nxt = S_LDPT;
      end

      // Fetch the coordinates of point p.
      S_LDPT: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt = 2'd0;
          pt_nxt[d_r[DIDX_W-1:0]] = $signed(pt_q);
          if (last_d) begin
            d_nxt     = '0;
            c_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = S_DIST;
          end else begin
            d_nxt = d_r + 1'b1;
          end
        end
      end

      // Squared distance to each centroid; keep the nearest.
      S_DIST: begin
        if (ph_r == 2'd0) begin
          ph_nxt     = 2'd1;
          cen_rv_nxt = cval_r[{c_r[CIDX_W-1:0], d_r[DIDX_W-1:0]}];
        end else begin
          ph_nxt = 2'd0;
          if (last_d) begin
            acc_nxt = '0;
            d_nxt   = '0;
            if (c_r == '0 || dd < bestd_r) begin
              bestd_nxt = dd;
              best_nxt  = c_r[CIDX_W-1:0];
            end
            if (last_c) begin
              state_nxt = S_UPD;
            end else begin
              c_nxt = c_r + 1'b1;
            end
          end else begin
            acc_nxt = dd;
            d_nxt   = d_r + 1'b1;
          end
        end
      end

      // Read-modify-write of the sums and count of the winning cluster; records the point's assignment.
      S_UPD: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt = 2'd0;
          sum_we = 1'b1;
          if (last_d) begin
            d_nxt    = '0;
            cnt_we   = 1'b1;
            asg_we   = 1'b1;
            sval_nxt[best_r] = 1'b1;
            p_nxt    = p_r + 1'b1;
            if (p_r == np_r - 1'b1) begin
              c_nxt     = '0;
              state_nxt = S_MEAN;
            end else begin
              state_nxt = S_LDPT;
            end
          end else begin
            d_nxt = d_r + 1'b1;
          end
        end
      end

      // New centroid = sum / count for every cluster that has points.
      S_MEAN: begin
        sum_addr  = {c_r[CIDX_W-1:0], d_r[DIDX_W-1:0]};
        cnt_addr  = c_r[CIDX_W-1:0];
        cen_wdata = div_quot;
        case (ph_r)
          2'd0: begin
            if (sval_r[c_r[CIDX_W-1:0]]) begin
              ph_nxt = 2'd1;
            end else if (last_c) begin
              it_nxt    = it_r + 1'b1;
              state_nxt = (it_r == nit_r - 1'b1) ? S_DONE : S_INIT;
            end else begin
              c_nxt = c_r + 1'b1;
            end
          end
          2'd1: begin
            div_req.start = 1'b1;
            ph_nxt        = 2'd2;
          end
          default: begin
            if (div_done) begin
              ph_nxt = 2'd0;
              cen_we = 1'b1;
              cval_nxt[{c_r[CIDX_W-1:0], d_r[DIDX_W-1:0]}] = 1'b1;
              if (last_d) begin
                d_nxt = '0;
                if (last_c) begin
                  it_nxt    = it_r + 1'b1;
                  state_nxt = (it_r == nit_r - 1'b1) ? S_DONE : S_INIT;
                end else begin
                  c_nxt = c_r + 1'b1;
                end
              end else begin
                d_nxt = d_r + 1'b1;
              end
            end
          end
        endcase
      end

      // Run finished: send the done word.
      S_DONE: begin
        pend_nxt  = 1'b1;
        pkind_nxt = RK_DONE;
        pok_nxt   = 1'b0;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Register update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ncl_r     <= NCL_W'(2);
      nit_r     <= NIT_W'(10);
      ndim_r    <= NDIM_W'(2);
      npt_r     <= NPT_W'(MAX_POINTS);
      cval_r    <= '0;
      sval_r    <= '0;
      asg_cnt_r <= '0;
      pend_r    <= 1'b0;
      ph_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      cval_r    <= cval_nxt;
      sval_r    <= sval_nxt;
      asg_cnt_r <= asg_cnt_nxt;
      pend_r    <= pend_nxt;
      ph_r      <= ph_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_CLUSTERS:   ncl_r  <= cfg_wdata[NCL_W-1:0];
          REG_NUM_ITERATIONS: nit_r  <= cfg_wdata[NIT_W-1:0];
          REG_DIMS_IN_USE:    ndim_r <= cfg_wdata[NDIM_W-1:0];
          REG_NUM_POINTS:     npt_r  <= cfg_wdata[NPT_W-1:0];
          default: ;
        endcase
      end
    end
    c_r      <= c_nxt;
    d_r      <= d_nxt;
    p_r      <= p_nxt;
    it_r     <= it_nxt;
    k_r      <= k_nxt;
    dims_r   <= dims_nxt;
    np_r     <= np_nxt;
    pt_r     <= pt_nxt;
    acc_r    <= acc_nxt;
    bestd_r  <= bestd_nxt;
    best_r   <= best_nxt;
    cen_rv_r <= cen_rv_nxt;
    pkind_r  <= pkind_nxt;
    pok_r    <= pok_nxt;
  end

  // Result word; read data comes straight from the registered RAM outputs.
  assign out_strobe         = pend_r;
  assign out_result_kind    = pkind_r;
  assign out_cluster_id     = (pkind_r == RK_ASG && pok_r) ? asg_q : '0;
  assign out_centroid_value = (pkind_r == RK_CENT && pok_r && cen_rv_r) ?
                              $signed(cen_q) : '0;

  // Memories.
  kml_ram #(.WIDTH(COORD_WIDTH), .DEPTH(PT_DEPTH)) u_pt_ram (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(in_coord_value),
    .raddr(pt_raddr), .rdata(pt_q)
  );

  kml_ram #(.WIDTH(COORD_WIDTH), .DEPTH(CENT_DEPTH)) u_cen_ram (
    .clk(clk), .we(cen_we), .waddr(cen_waddr), .wdata(cen_wdata),
    .raddr(cen_raddr), .rdata(cen_q)
  );

  kml_ram #(.WIDTH(SUM_W), .DEPTH(CENT_DEPTH)) u_sum_ram (
    .clk(clk), .we(sum_we), .waddr(sum_addr), .wdata(sum_wdata),
    .raddr(sum_addr), .rdata(sum_q)
  );

  kml_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CLUSTERS)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_addr), .wdata(cnt_wdata),
    .raddr(cnt_addr), .rdata(cnt_q)
  );

  kml_ram #(.WIDTH(CIDX_W), .DEPTH(MAX_POINTS)) u_asg_ram (
    .clk(clk), .we(asg_we), .waddr(asg_waddr), .wdata(best_r),
    .raddr(asg_raddr), .rdata(asg_q)
  );

  // Mean divider.
  kml_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .quot(div_quot)
  );

  // Checks.
  a_done_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result_kind == RK_DONE) |-> $past(state_r == S_DONE))
    else $error("done word without a finished run");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == CMD_RUN) |=> busy)
    else $error("run accepted but block not busy");

  a_div_in_mean: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_MEAN && ph_r == 2'd2))
    else $error("divider finished outside the mean step");

endmodule
